// ----- sv/fsp_pkg.sv -----
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types, character constants and byte classifiers for the printf
// format specifier parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    M_TEXT  = 3'd0,
    M_PCT   = 3'd1,
    M_FLAGS = 3'd2,
    M_WIDTH = 3'd3,
    M_DOT   = 3'd4,
    M_PREC  = 3'd5,
    M_ERR   = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_STARW  = 3'd1,
    ST_STARP  = 3'd2,
    ST_LENMOD = 3'd3,
    ST_TRUNC  = 3'd4,
    ST_UNSUP  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CLS_INT   = 2'd0,
    CLS_FLOAT = 2'd1,
    CLS_STR   = 2'd2
  } cls_t;

  localparam logic KIND_ARG    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // parser state carried between bytes
  typedef struct packed {
    mode_t      mode;
    status_t    code;
    logic [7:0] bad;
  } parse_state_t;

  // one result item
  typedef struct packed {
    logic       kind;
    cls_t       arg_class;
    status_t    status;
    logic [7:0] bad_char;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t item;
  } step_out_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_flag(input logic [7:0] c);
    return (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SPACE) ||
           (c == CH_HASH) || (c == CH_ZERO);
  endfunction

  // length modifiers: l h z j t L
  function automatic logic is_length(input logic [7:0] c);
    return (c == 8'h6C) || (c == 8'h68) || (c == 8'h7A) ||
           (c == 8'h6A) || (c == 8'h74) || (c == 8'h4C);
  endfunction

endpackage

// ----- sv/fsp_step.sv -----
// ----------------------------------------------------------------------------
// fsp_step
// Per-byte transition of the specifier parser: next parser state and the
// result item (if any) that one byte causes.
// ----------------------------------------------------------------------------
module fsp_step (
  input  fsp_pkg::parse_state_t cur,
  input  logic [7:0]            ch,
  output fsp_pkg::parse_state_t nxt,
  output fsp_pkg::step_out_t    res
);

  logic             conv_ok;
  fsp_pkg::cls_t    conv_cls;
  fsp_pkg::status_t conv_code;
  logic             to_conv;

  // conversion byte decode
  always_comb begin
    conv_ok   = 1'b0;
    conv_cls  = fsp_pkg::CLS_INT;
    conv_code = fsp_pkg::ST_UNSUP;
    if (fsp_pkg::is_length(ch)) begin
      conv_code = fsp_pkg::ST_LENMOD;
    end else begin
      case (ch)
        8'h64, 8'h69, 8'h75, 8'h63, 8'h78, 8'h58, 8'h6F: begin  // d i u c x X o
          conv_ok  = 1'b1;
          conv_cls = fsp_pkg::CLS_INT;
        end
        8'h66, 8'h46, 8'h65, 8'h45, 8'h67, 8'h47: begin         // f F e E g G
          conv_ok  = 1'b1;
          conv_cls = fsp_pkg::CLS_FLOAT;
        end
        8'h73: begin                                            // s
          conv_ok  = 1'b1;
          conv_cls = fsp_pkg::CLS_STR;
        end
        default: begin
          conv_ok = 1'b0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    nxt     = cur;
    to_conv = 1'b0;
    if (ch == fsp_pkg::CH_NUL) begin
      nxt.mode = fsp_pkg::M_TEXT;
      nxt.code = fsp_pkg::ST_OK;
      nxt.bad  = 8'h00;
    end else begin
      case (cur.mode)
        fsp_pkg::M_PCT, fsp_pkg::M_FLAGS: begin
          if (cur.mode == fsp_pkg::M_PCT && ch == fsp_pkg::CH_PCT) begin
            nxt.mode = fsp_pkg::M_TEXT;  // literal percent
          end else if (fsp_pkg::is_flag(ch)) begin
            nxt.mode = fsp_pkg::M_FLAGS;
          end else if (ch == fsp_pkg::CH_STAR) begin
            nxt.mode = fsp_pkg::M_ERR;
            nxt.code = fsp_pkg::ST_STARW;
            nxt.bad  = 8'h00;
          end else if (fsp_pkg::is_digit(ch)) begin
            nxt.mode = fsp_pkg::M_WIDTH;
          end else if (ch == fsp_pkg::CH_DOT) begin
            nxt.mode = fsp_pkg::M_DOT;
          end else begin
            to_conv = 1'b1;
          end
        end
        fsp_pkg::M_WIDTH: begin
          if (fsp_pkg::is_digit(ch)) begin
            nxt.mode = fsp_pkg::M_WIDTH;
          end else if (ch == fsp_pkg::CH_DOT) begin
            nxt.mode = fsp_pkg::M_DOT;
          end else begin
            to_conv = 1'b1;
          end
        end
        fsp_pkg::M_DOT: begin
          if (ch == fsp_pkg::CH_STAR) begin
            nxt.mode = fsp_pkg::M_ERR;
            nxt.code = fsp_pkg::ST_STARP;
            nxt.bad  = 8'h00;
          end else if (fsp_pkg::is_digit(ch)) begin
            nxt.mode = fsp_pkg::M_PREC;
          end else begin
            to_conv = 1'b1;
          end
        end
        fsp_pkg::M_PREC: begin
          if (!fsp_pkg::is_digit(ch)) begin
            to_conv = 1'b1;
          end
        end
        fsp_pkg::M_ERR: begin
          nxt = cur;
        end
        default: begin
          nxt.mode = (ch == fsp_pkg::CH_PCT) ? fsp_pkg::M_PCT : fsp_pkg::M_TEXT;
        end
      endcase
      if (to_conv) begin
        if (conv_ok) begin
          nxt.mode = fsp_pkg::M_TEXT;
        end else begin
          nxt.mode = fsp_pkg::M_ERR;
          nxt.code = conv_code;
          nxt.bad  = (conv_code == fsp_pkg::ST_UNSUP) ? ch : 8'h00;
        end
      end
    end
  end

  // result item
  always_comb begin
    res.emit           = 1'b0;
    res.item.kind      = fsp_pkg::KIND_ARG;
    res.item.arg_class = fsp_pkg::CLS_INT;
    res.item.status    = fsp_pkg::ST_OK;
    res.item.bad_char  = 8'h00;
    if (ch == fsp_pkg::CH_NUL) begin
      res.emit      = 1'b1;
      res.item.kind = fsp_pkg::KIND_STATUS;
      if (cur.mode == fsp_pkg::M_ERR) begin
        res.item.status   = cur.code;
        res.item.bad_char = (cur.code == fsp_pkg::ST_UNSUP) ? cur.bad : 8'h00;
      end else if (cur.mode != fsp_pkg::M_TEXT) begin
        res.item.status = fsp_pkg::ST_TRUNC;
      end
    end else if (to_conv && conv_ok) begin
      res.emit           = 1'b1;
      res.item.arg_class = conv_cls;
    end
  end

endmodule

// ----- sv/format_string_signature_parser_top.sv -----
// ----------------------------------------------------------------------------
// format_string_signature_parser_top
// printf format specifier parser: one byte of a format string per item,
// argument classes out per conversion and a final status per string.
// ----------------------------------------------------------------------------
// Flow: an accepted byte is held in the input register; its result, if any,
//   is then written into the result queue and offered on out_*.
// Throughput: one byte per cycle while the result queue has room.
// A two-entry result queue lets bytes keep flowing while a result waits.
// Reset (rst, synchronous): parser back to text mode, no error, queue empty.
// ----------------------------------------------------------------------------
module format_string_signature_parser_top #(
  parameter int unsigned QDEPTH = fsp_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  // byte channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [1:0] arg_class,
  output logic [2:0] status,
  output logic [7:0] bad_char
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  // input register
  logic       stg_valid;
  logic [7:0] stg_ch;
  logic       stg_fire;

  // parser state
  fsp_pkg::parse_state_t pstate;
  fsp_pkg::parse_state_t pstate_next;
  fsp_pkg::step_out_t    step_res;

  // result queue
  fsp_pkg::result_t q [QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  // The staged byte moves on whenever the queue has room, so the queue
  // can never overflow even when the byte emits a result.
  assign stg_fire = stg_valid && (count != CW'(QDEPTH));
  assign in_ready = !stg_valid || stg_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_ch <= ch;
    end
  end

  fsp_step u_step (
    .cur (pstate),
    .ch  (stg_ch),
    .nxt (pstate_next),
    .res (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate.mode <= fsp_pkg::M_TEXT;
      pstate.code <= fsp_pkg::ST_OK;
      pstate.bad  <= 8'h00;
    end else if (stg_fire) begin
      pstate <= pstate_next;
    end
  end

  // queue bookkeeping
  assign push = stg_fire && step_res.emit;
  assign pop  = out_valid && out_ready;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= step_res.item;
    end
  end

  assign out_valid = (count != '0);
  assign kind      = q[rd_ptr].kind;
  assign arg_class = q[rd_ptr].arg_class;
  assign status    = q[rd_ptr].status;
  assign bad_char  = q[rd_ptr].bad_char;

endmodule

// ----- sv/fsp_check.sv -----
// ----------------------------------------------------------------------------
// fsp_check
// Port-level checks for the format specifier parser, bound to the top level.
// ----------------------------------------------------------------------------
module fsp_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] ch,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [1:0] arg_class,
  input logic [2:0] status,
  input logic [7:0] bad_char
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(arg_class) &&
      $stable(status) && $stable(bad_char))
    else $error("result changed while stalled");

  // argument items carry a class only
  a_arg_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == fsp_pkg::KIND_ARG |->
      arg_class != 2'd3 && status == fsp_pkg::ST_OK && bad_char == 8'h00)
    else $error("malformed argument item");

  // status items carry a legal code and no class
  a_status_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == fsp_pkg::KIND_STATUS |->
      arg_class == fsp_pkg::CLS_INT && status != 3'd6 && status != 3'd7)
    else $error("malformed status item");

  // offending byte present exactly for unsupported conversion
  a_bad_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == fsp_pkg::KIND_STATUS |->
      ((status == fsp_pkg::ST_UNSUP) == (bad_char != 8'h00)))
    else $error("bad_char inconsistent with status");

  // nothing offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind format_string_signature_parser_top fsp_check u_fsp_check (.*);
